/* sv/ial_pkg.sv */
// ial_pkg: shared constants, codes and types for the indexed insert/remove list.
// Used by ial_ram, ial_ctrl and indexed_insert_remove_list. No dependencies.
package ial_pkg;

  localparam int DEPTH = 64;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int DW    = 32;

  localparam logic [CW-1:0] CAP_RESET = CW'(DEPTH);
  localparam logic [CW-1:0] CAP_MAX   = CW'(DEPTH);

  localparam logic [1:0] REG_CAPACITY = 2'd0;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_PEEK   = 2'd2,
    ACT_NOP    = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GOT,
    S_MOVE_RD,
    S_MOVE_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic [DW-1:0] wdata;
    logic [AW-1:0] raddr;
  } ram_req_t;

endpackage

/* sv/ial_ram.sv */
// ial_ram: entry store, one write port and one registered read port.
// Depends on ial_pkg for depth and the request struct.
module ial_ram (
  input  logic                        clk,
  input  ial_pkg::ram_req_t           req,
  output logic [ial_pkg::DW-1:0]      rdata
);

  logic [ial_pkg::DW-1:0] mem [ial_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

/* sv/ial_ctrl.sv */
// ial_ctrl: sequencer that steps one index counter up or down to shift entries.
// Depends on ial_pkg; drives ial_ram through a ram_req_t.
module ial_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_action,
  input  logic signed [31:0]          in_value,
  input  logic [6:0]                  in_position,
  input  logic                        in_at_end,
  input  logic [ial_pkg::CW-1:0]      cap_eff,
  output ial_pkg::ram_req_t           ram_req,
  input  logic [ial_pkg::DW-1:0]      ram_rdata,
  output logic                        out_valid,
  output logic [1:0]                  out_status,
  output logic signed [31:0]          out_result_value,
  output logic [5:0]                  out_index_used,
  output logic [6:0]                  out_occupancy
);

  ial_pkg::state_t           st_r, st_nxt;
  ial_pkg::act_t             act_r, act_nxt, act_in;
  ial_pkg::status_t          stat_r, stat_nxt;
  logic [ial_pkg::CW-1:0]    cnt_r, cnt_nxt;
  logic [ial_pkg::CW-1:0]    i_r, i_nxt;
  logic [ial_pkg::CW-1:0]    lim_r, lim_nxt;
  logic [ial_pkg::AW-1:0]    idx_r, idx_nxt;
  logic [ial_pkg::DW-1:0]    res_r, res_nxt;
  logic [ial_pkg::DW-1:0]    val_r, val_nxt;
  logic [ial_pkg::CW-1:0]    step_i;
  logic                      at_lim;
  logic [ial_pkg::CW-1:0]    pos_in;
  logic [ial_pkg::CW-1:0]    pos_rm;
  logic                      accept;

  assign act_in = ial_pkg::act_t'(in_action);
  assign accept = start && (st_r == ial_pkg::S_IDLE);

  // shared step and compare
  assign step_i = (act_r == ial_pkg::ACT_INSERT) ? i_r - 1'b1 : i_r + 1'b1;
  assign at_lim = (i_r == lim_r);

  assign pos_in = (in_at_end || (in_position > cnt_r)) ? cnt_r : in_position;
  assign pos_rm = (in_at_end || (in_position >= cnt_r)) ? cnt_r - 1'b1 : in_position;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ial_pkg::S_IDLE: begin
        if (start) begin
          case (act_in)
            ial_pkg::ACT_INSERT: begin
              st_nxt = (cnt_r >= cap_eff) ? ial_pkg::S_DONE : ial_pkg::S_MOVE_RD;
            end
            ial_pkg::ACT_REMOVE, ial_pkg::ACT_PEEK: begin
              st_nxt = (cnt_r == '0) ? ial_pkg::S_DONE : ial_pkg::S_GOT;
            end
            default: st_nxt = ial_pkg::S_DONE;
          endcase
        end
      end
      ial_pkg::S_GOT: begin
        st_nxt = (act_r == ial_pkg::ACT_PEEK) ? ial_pkg::S_DONE : ial_pkg::S_MOVE_RD;
      end
      ial_pkg::S_MOVE_RD: st_nxt = at_lim ? ial_pkg::S_DONE : ial_pkg::S_MOVE_WR;
      ial_pkg::S_MOVE_WR: st_nxt = ial_pkg::S_MOVE_RD;
      ial_pkg::S_DONE:    st_nxt = ial_pkg::S_IDLE;
      default:            st_nxt = ial_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    act_nxt        = act_r;
    stat_nxt       = stat_r;
    cnt_nxt        = cnt_r;
    i_nxt          = i_r;
    lim_nxt        = lim_r;
    idx_nxt        = idx_r;
    res_nxt        = res_r;
    val_nxt        = val_r;
    ram_req.we     = 1'b0;
    ram_req.waddr  = i_r[ial_pkg::AW-1:0];
    ram_req.wdata  = ram_rdata;
    ram_req.raddr  = step_i[ial_pkg::AW-1:0];
    case (st_r)
      ial_pkg::S_IDLE: begin
        if (accept) begin
          act_nxt  = act_in;
          val_nxt  = in_value;
          stat_nxt = ial_pkg::ST_DONE;
          res_nxt  = '0;
          idx_nxt  = '0;
          case (act_in)
            ial_pkg::ACT_INSERT: begin
              res_nxt = in_value;
              if (cnt_r >= cap_eff) begin
                stat_nxt = ial_pkg::ST_FULL;
              end else begin
                i_nxt   = cnt_r;
                lim_nxt = pos_in;
                idx_nxt = pos_in[ial_pkg::AW-1:0];
              end
            end
            ial_pkg::ACT_REMOVE: begin
              if (cnt_r == '0) begin
                stat_nxt = ial_pkg::ST_EMPTY;
              end else begin
                i_nxt         = pos_rm;
                lim_nxt       = cnt_r - 1'b1;
                idx_nxt       = pos_rm[ial_pkg::AW-1:0];
                ram_req.raddr = pos_rm[ial_pkg::AW-1:0];
              end
            end
            ial_pkg::ACT_PEEK: begin
              ram_req.raddr = '0;
              if (cnt_r == '0) begin
                stat_nxt = ial_pkg::ST_EMPTY;
              end
            end
            default: ;
          endcase
        end
      end
      ial_pkg::S_GOT: res_nxt = ram_rdata;
      ial_pkg::S_MOVE_RD: begin
        if (at_lim) begin
          if (act_r == ial_pkg::ACT_INSERT) begin
            ram_req.we    = 1'b1;
            ram_req.wdata = val_r;
            cnt_nxt       = cnt_r + 1'b1;
          end else begin
            cnt_nxt = cnt_r - 1'b1;
          end
        end
      end
      ial_pkg::S_MOVE_WR: begin
        ram_req.we = 1'b1;
        i_nxt      = step_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ial_pkg::S_IDLE;
      cnt_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r  <= act_nxt;
    stat_r <= stat_nxt;
    i_r    <= i_nxt;
    lim_r  <= lim_nxt;
    idx_r  <= idx_nxt;
    res_r  <= res_nxt;
    val_r  <= val_nxt;
  end

  assign busy             = (st_r != ial_pkg::S_IDLE);
  assign out_valid        = (st_r == ial_pkg::S_DONE);
  assign out_status       = stat_r;
  assign out_result_value = res_r;
  assign out_index_used   = idx_r;
  assign out_occupancy    = cnt_r;

endmodule

/* sv/indexed_insert_remove_list.sv */
// Indexed insert/remove list top: APB capacity register, sequencer and entry RAM.
// From accept to out_valid (S_DONE): reject or unused action goes straight to S_DONE;
// peek and remove read their entry in S_GOT; insert and remove then alternate S_MOVE_RD
// and S_MOVE_WR per moved entry via the single RAM port pair; busy drops the cycle after.
// No new item is taken while busy. Results are never stalled by the receiver.
// rst_n (sync, active low) clears the count and sets capacity to 64; entries are not cleared.
module indexed_insert_remove_list (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_action,
  input  logic signed [31:0]  in_value,
  input  logic [6:0]          in_position,
  input  logic                in_at_end,
  output logic                out_valid,
  output logic [1:0]          out_status,
  output logic signed [31:0]  out_result_value,
  output logic [5:0]          out_index_used,
  output logic [6:0]          out_occupancy,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [1:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [ial_pkg::CW-1:0] cfg_capacity_r;
  logic [ial_pkg::CW-1:0] cap_eff;
  logic                   cfg_wr;
  ial_pkg::ram_req_t      ram_req;
  logic [ial_pkg::DW-1:0] ram_rdata;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == ial_pkg::REG_CAPACITY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_capacity_r <= ial_pkg::CAP_RESET;
    end else if (cfg_wr) begin
      cfg_capacity_r <= pwdata[ial_pkg::CW-1:0];
    end
  end

  assign prdata  = 32'(cfg_capacity_r);
  assign cap_eff = (cfg_capacity_r > ial_pkg::CAP_MAX) ? ial_pkg::CAP_MAX : cfg_capacity_r;

  ial_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_value         (in_value),
    .in_position      (in_position),
    .in_at_end        (in_at_end),
    .cap_eff          (cap_eff),
    .ram_req          (ram_req),
    .ram_rdata        (ram_rdata),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_result_value (out_result_value),
    .out_index_used   (out_index_used),
    .out_occupancy    (out_occupancy)
  );

  ial_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

endmodule

/* tb/ial_list_checker.sv */
// Checker for indexed_insert_remove_list: watches the item, result and APB ports,
// keeps its own copy of the list and capacity, and compares every result beat in order.
// Depends on ial_pkg for widths and codes.
`timescale 1ns / 100ps
module ial_list_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_value,
  input  logic [6:0]  in_position,
  input  logic        in_at_end,
  input  logic        out_valid,
  input  logic [1:0]  out_status,
  input  logic [31:0] out_result_value,
  input  logic [5:0]  out_index_used,
  input  logic [6:0]  out_occupancy,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          err_count,
  output int          awaiting,
  output int          full_rejects,
  output int          empty_rejects,
  output int          peak_occ
);

  localparam logic [1:0] CAP_ADDR = 2'(ial_pkg::REG_CAPACITY * 4);

  typedef struct {
    logic [1:0]             status;
    logic [ial_pkg::DW-1:0] value;
    logic [ial_pkg::AW-1:0] idx;
    logic [ial_pkg::CW-1:0] occ;
  } list_reply_t;

  logic [ial_pkg::DW-1:0] list_mem [ial_pkg::DEPTH];
  int unsigned            list_len;
  logic [ial_pkg::CW-1:0] capacity;
  list_reply_t            awaited [$];
  int                     errs;

  initial begin
    errs = 0;
    full_rejects = 0;
    empty_rejects = 0;
    peak_occ = 0;
    err_count = 0;
    awaiting = 0;
    list_len = 0;
    capacity = ial_pkg::CAP_RESET;
  end

  function automatic list_reply_t apply_list_op(logic [1:0] act, logic [ial_pkg::DW-1:0] val,
                                                logic [6:0] pos, logic ae);
    list_reply_t r;
    int unsigned limit;
    int unsigned slot;
    limit = (capacity > ial_pkg::CAP_MAX) ? ial_pkg::CAP_MAX : capacity;
    r.status = ial_pkg::ST_DONE;
    r.value = '0;
    r.idx = '0;
    case (act)
      ial_pkg::ACT_INSERT: begin
        if (list_len >= limit) begin
          r.status = ial_pkg::ST_FULL;
          r.value = val;
          full_rejects++;
        end else begin
          slot = (ae || pos > list_len) ? list_len : pos;
          for (int i = list_len; i > slot; i--) list_mem[i] = list_mem[i-1];
          list_mem[slot] = val;
          list_len++;
          r.value = val;
          r.idx = ial_pkg::AW'(slot);
        end
      end
      ial_pkg::ACT_REMOVE: begin
        if (list_len == 0) begin
          r.status = ial_pkg::ST_EMPTY;
          empty_rejects++;
        end else begin
          slot = (ae || pos >= list_len) ? list_len - 1 : pos;
          r.value = list_mem[slot];
          r.idx = ial_pkg::AW'(slot);
          for (int i = slot; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      ial_pkg::ACT_PEEK: begin
        if (list_len == 0) begin
          r.status = ial_pkg::ST_EMPTY;
          empty_rejects++;
        end else begin
          r.value = list_mem[0];
        end
      end
      default: ;
    endcase
    r.occ = ial_pkg::CW'(list_len);
    if (list_len > peak_occ) peak_occ = list_len;
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s expected 0x%08h got 0x%08h", name, exp_v, got_v);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    list_reply_t exp_r;
    if (!rst_n) begin
      list_len = 0;
      capacity = ial_pkg::CAP_RESET;
      awaited.delete();
    end else begin
      if (psel === 1'b1 && penable === 1'b1 && pready === 1'b1 && paddr == CAP_ADDR) begin
        if (pwrite) capacity = pwdata[ial_pkg::CW-1:0];
        else compare_field("capacity", 32'(capacity), 32'(prdata[ial_pkg::CW-1:0]));
      end
      if (out_valid === 1'b1) begin
        if (awaited.size() == 0) begin
          $error("result beat with no item outstanding");
          errs++;
        end else begin
          exp_r = awaited.pop_front();
          compare_field("status", 32'(exp_r.status), 32'(out_status));
          compare_field("result_value", exp_r.value, out_result_value);
          compare_field("index_used", 32'(exp_r.idx), 32'(out_index_used));
          compare_field("occupancy", 32'(exp_r.occ), 32'(out_occupancy));
        end
      end
      if (start === 1'b1 && busy === 1'b0)
        awaited.push_back(apply_list_op(in_action, in_value, in_position, in_at_end));
    end
    awaiting <= awaited.size();
    err_count <= errs;
  end

  final begin
    if (awaited.size() != 0) $error("%0d results never arrived", awaited.size());
  end

endmodule

/* tb/tb_indexed_insert_remove_list.sv */
// Top of the indexed_insert_remove_list testbench: clock, reset, APB capacity writes and
// item stimulus (directed, then random phases). Checking lives in ial_list_checker.
// Depends on ial_pkg and the block's RTL.
`timescale 1ns / 100ps
module tb_indexed_insert_remove_list;

  localparam logic [1:0] CAP_ADDR = 2'(ial_pkg::REG_CAPACITY * 4);
  localparam int SETTLE_CYCLES = 2 * ial_pkg::DEPTH + 8;
  localparam logic [ial_pkg::CW-1:0] CAP_STEPS [8] = '{7'd64, 7'd127, 7'd0, 7'd5,
                                                        7'd65, 7'd1, 7'd33, 7'd64};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic [1:0]  in_action = ial_pkg::ACT_NOP;
  logic [31:0] in_value = '0;
  logic [6:0]  in_position = '0;
  logic        in_at_end = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic        busy;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [31:0] out_result_value;
  logic [5:0]  out_index_used;
  logic [6:0]  out_occupancy;
  logic [31:0] prdata;
  logic        pready;

  int err_count, awaiting, full_rejects, empty_rejects, peak_occ;
  bit no_gaps = 1'b0;
  int unsigned n_insert = 0, n_remove = 0, n_peek = 0, n_unused = 0, n_settings = 0;

  indexed_insert_remove_list dut (.*);
  ial_list_checker chk (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("indexed_insert_remove_list test failed");
    $finish;
  end

  task automatic send_item(input logic [1:0] act, input logic [31:0] val,
                           input logic [6:0] pos, input logic ae);
    if (!no_gaps && $urandom_range(99) < 33) begin
      start <= 1'b0;
      if ($urandom_range(9) == 0) repeat ($urandom_range(140, 20)) @(posedge clk);
      else repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    start <= 1'b1;
    in_action <= act;
    in_value <= val;
    in_position <= pos;
    in_at_end <= ae;
    do @(posedge clk); while (busy !== 1'b0);
    case (act)
      ial_pkg::ACT_INSERT: n_insert++;
      ial_pkg::ACT_REMOVE: n_remove++;
      ial_pkg::ACT_PEEK:   n_peek++;
      default:             n_unused++;
    endcase
  endtask

  task automatic send_random(input int unsigned ins_pct);
    logic [1:0]  act;
    logic [31:0] val;
    logic [6:0]  pos;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 4) act = ial_pkg::ACT_NOP;
    else if (roll < 14) act = ial_pkg::ACT_PEEK;
    else if ($urandom_range(99) < ins_pct) act = ial_pkg::ACT_INSERT;
    else act = ial_pkg::ACT_REMOVE;
    case ($urandom_range(7))
      0: val = 32'h8000_0000;
      1: val = 32'h7fff_ffff;
      2: val = '1;
      default: val = $urandom();
    endcase
    case ($urandom_range(3))
      0: pos = 7'($urandom_range(127));
      1: pos = 7'($urandom_range(66));
      default: pos = 7'($urandom_range(15));
    endcase
    send_item(act, val, pos, $urandom_range(3) == 0);
  endtask

  // park the sender until every result is back and the block is idle
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (awaiting != 0 || busy !== 1'b0) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= CAP_ADDR;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_capacity(input logic [ial_pkg::CW-1:0] cap);
    wait_drained();
    apb_access(1'b1, 32'(cap));
    apb_access(1'b0, '0);
    n_settings++;
  endtask

  initial begin
    int unsigned ins_pct;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset value, empty list, unused code, inserts at front/past end/end flag/middle, then peek and removes
    apb_access(1'b0, '0);
    send_item(ial_pkg::ACT_PEEK, $urandom(), 7'd0, 1'b0);
    send_item(ial_pkg::ACT_REMOVE, $urandom(), 7'd0, 1'b0);
    send_item(ial_pkg::ACT_REMOVE, '0, 7'd127, 1'b1);
    send_item(ial_pkg::ACT_NOP, $urandom(), 7'($urandom()), 1'b0);
    send_item(ial_pkg::ACT_INSERT, 32'h7fff_ffff, 7'd0, 1'b0);
    send_item(ial_pkg::ACT_INSERT, 32'h8000_0000, 7'd127, 1'b0);
    send_item(ial_pkg::ACT_INSERT, 32'hffff_ffff, 7'd0, 1'b1);
    send_item(ial_pkg::ACT_INSERT, 32'h0000_0000, 7'd1, 1'b0);
    send_item(ial_pkg::ACT_INSERT, 32'h5555_5555, 7'd4, 1'b0);
    send_item(ial_pkg::ACT_PEEK, '0, 7'd3, 1'b1);
    send_item(ial_pkg::ACT_REMOVE, '0, 7'd1, 1'b0);
    send_item(ial_pkg::ACT_REMOVE, '0, 7'd127, 1'b0);
    send_item(ial_pkg::ACT_REMOVE, '0, 7'd0, 1'b1);
    send_item(ial_pkg::ACT_REMOVE, '0, 7'd0, 1'b0);
    send_item(ial_pkg::ACT_NOP, 32'hffff_ffff, 7'd127, 1'b1);

    // full at a small capacity, capacity below occupancy, zero capacity
    set_capacity(7'd2);
    send_item(ial_pkg::ACT_INSERT, 32'haaaa_aaaa, 7'd0, 1'b0);
    send_item(ial_pkg::ACT_INSERT, 32'h1234_5678, 7'd0, 1'b0);
    send_item(ial_pkg::ACT_PEEK, '0, 7'd0, 1'b0);
    set_capacity(7'd1);
    send_item(ial_pkg::ACT_INSERT, 32'h0f0f_0f0f, 7'd0, 1'b0);
    send_item(ial_pkg::ACT_REMOVE, '0, 7'd0, 1'b0);
    set_capacity(7'd0);
    send_item(ial_pkg::ACT_INSERT, 32'hdead_0001, 7'd0, 1'b1);
    send_item(ial_pkg::ACT_REMOVE, '0, 7'd5, 1'b1);
    send_item(ial_pkg::ACT_REMOVE, '0, 7'd0, 1'b0);

    foreach (CAP_STEPS[p]) begin
      set_capacity(CAP_STEPS[p]);
      no_gaps = (p == 3);
      for (int b = 0; b < 5; b++) begin
        case ($urandom_range(2))
          0: ins_pct = 80;
          1: ins_pct = 50;
          default: ins_pct = 25;
        endcase
        for (int k = 0; k < 26; k++) send_random(ins_pct);
        if (p == 4 && b == 2) wait_drained();
      end
    end
    no_gaps = 1'b0;

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d inserts, %0d removes, %0d peeks, %0d unused codes over %0d capacities",
             n_insert, n_remove, n_peek, n_unused, n_settings + 1);
    $display("Saw %0d full rejects, %0d empty rejects, peak occupancy %0d",
             full_rejects, empty_rejects, peak_occ);
    if (err_count == 0) begin
      $display("indexed_insert_remove_list test passed");
    end else begin
      $display("indexed_insert_remove_list test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/ial_pkg.sv
sv/ial_ram.sv
sv/ial_ctrl.sv
sv/indexed_insert_remove_list.sv
tb/ial_list_checker.sv
tb/tb_indexed_insert_remove_list.sv
